// File: rtl/rne_pkg.sv
// rne_pkg: shared types, character codes and the symbol lookup for the roman
// numeral encoder
// no dependencies
package rne_pkg;

  localparam int unsigned VALUE_W = 13;
  localparam int unsigned REM_W   = 12;
  localparam int unsigned WGT_W   = 10;
  localparam int unsigned CHAR_W  = 7;

  localparam logic [VALUE_W-1:0] VALUE_LIMIT = 13'd4000;

  localparam logic [CHAR_W-1:0] CH_M = 7'h4D;
  localparam logic [CHAR_W-1:0] CH_D = 7'h44;
  localparam logic [CHAR_W-1:0] CH_C = 7'h43;
  localparam logic [CHAR_W-1:0] CH_L = 7'h4C;
  localparam logic [CHAR_W-1:0] CH_X = 7'h58;
  localparam logic [CHAR_W-1:0] CH_V = 7'h56;
  localparam logic [CHAR_W-1:0] CH_I = 7'h49;
  localparam logic [CHAR_W-1:0] CH_NONE = 7'h00;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_BUSY = 1'b1
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_full;
    logic step_last;
  } status_t;

  // one greedy symbol: a single letter or a subtractive pair
  typedef struct packed {
    logic [WGT_W-1:0]  weight;
    logic [CHAR_W-1:0] first;
    logic [CHAR_W-1:0] second;
    logic              pair;
  } sym_t;

  function automatic sym_t mk_sym(input logic [WGT_W-1:0] w, input logic [CHAR_W-1:0] a,
                                  input logic [CHAR_W-1:0] b, input logic p);
    sym_t s;
    s.weight = w;
    s.first  = a;
    s.second = b;
    s.pair   = p;
    return s;
  endfunction

  // largest symbol whose weight does not exceed the remainder
  function automatic sym_t rne_lookup(input logic [REM_W-1:0] rem);
    sym_t s;
    if (rem >= 12'd1000)     s = mk_sym(10'd1000, CH_M, CH_M, 1'b0);
    else if (rem >= 12'd900) s = mk_sym(10'd900,  CH_C, CH_M, 1'b1);
    else if (rem >= 12'd500) s = mk_sym(10'd500,  CH_D, CH_D, 1'b0);
    else if (rem >= 12'd400) s = mk_sym(10'd400,  CH_C, CH_D, 1'b1);
    else if (rem >= 12'd100) s = mk_sym(10'd100,  CH_C, CH_C, 1'b0);
    else if (rem >= 12'd90)  s = mk_sym(10'd90,   CH_X, CH_C, 1'b1);
    else if (rem >= 12'd50)  s = mk_sym(10'd50,   CH_L, CH_L, 1'b0);
    else if (rem >= 12'd40)  s = mk_sym(10'd40,   CH_X, CH_L, 1'b1);
    else if (rem >= 12'd10)  s = mk_sym(10'd10,   CH_X, CH_X, 1'b0);
    else if (rem >= 12'd9)   s = mk_sym(10'd9,    CH_I, CH_X, 1'b1);
    else if (rem >= 12'd5)   s = mk_sym(10'd5,    CH_V, CH_V, 1'b0);
    else if (rem >= 12'd4)   s = mk_sym(10'd4,    CH_I, CH_V, 1'b1);
    else                     s = mk_sym(10'd1,    CH_I, CH_I, 1'b0);
    return s;
  endfunction

endpackage

// File: rtl/rne_datapath.sv
// rne_datapath: remainder register, symbol lookup and the output register
// depends on rne_pkg
module rne_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rne_pkg::cmd_t                cmd,
  output rne_pkg::status_t             status,
  input  logic [rne_pkg::VALUE_W-1:0]  in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rne_pkg::CHAR_W-1:0]   out_char_code,
  output logic                         out_out_of_range,
  output logic                         out_last
);
  import rne_pkg::*;

  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic              half_r, half_nxt;
  logic              err_r, err_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] char_r, char_nxt;
  logic              oor_r, oor_nxt;
  logic              last_r, last_nxt;
  sym_t              sym;
  logic              at_weight;

  assign sym       = rne_lookup(rem_r);
  assign at_weight = (rem_r == {{(REM_W-WGT_W){1'b0}}, sym.weight});

  always_comb begin
    rem_nxt       = rem_r;
    half_nxt      = half_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_ready;
    char_nxt      = char_r;
    oor_nxt       = oor_r;
    last_nxt      = last_r;
    status.out_full  = out_valid_r;
    status.step_last = err_r || ((!sym.pair || half_r) && at_weight);

    if (cmd.load) begin
      err_nxt  = (in_value == '0) || (in_value >= VALUE_LIMIT);
      rem_nxt  = in_value[REM_W-1:0];
      half_nxt = 1'b0;
    end else if (cmd.step) begin
      out_valid_nxt = 1'b1;
      if (err_r) begin
        char_nxt = CH_NONE;
        oor_nxt  = 1'b1;
        last_nxt = 1'b1;
      end else if (sym.pair && !half_r) begin
        // leading letter of a subtractive pair
        char_nxt = sym.first;
        oor_nxt  = 1'b0;
        last_nxt = 1'b0;
        half_nxt = 1'b1;
      end else begin
        char_nxt = half_r ? sym.second : sym.first;
        oor_nxt  = 1'b0;
        last_nxt = at_weight;
        half_nxt = 1'b0;
        rem_nxt  = rem_r - {{(REM_W-WGT_W){1'b0}}, sym.weight};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      half_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      half_r      <= half_nxt;
    end
    rem_r  <= rem_nxt;
    err_r  <= err_nxt;
    char_r <= char_nxt;
    oor_r  <= oor_nxt;
    last_r <= last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_char_code    = char_r;
  assign out_out_of_range = oor_r;
  assign out_last         = last_r;

  // a step must never overwrite a character still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step && out_valid_r |-> out_ready)
    else $error("output register overwritten");

  a_no_load_and_step: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.step))
    else $error("load and step together");

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step && err_r |=> out_valid_r && oor_r && last_r && (char_r == CH_NONE))
    else $error("out of range transaction malformed");

  a_pair_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step && !err_r && sym.pair && !half_r |=> half_r && !last_r)
    else $error("subtractive pair split wrongly");

endmodule

// File: rtl/rne_ctrl.sv
// rne_ctrl: controller state machine, issues load and step commands
// depends on rne_pkg
module rne_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  input  rne_pkg::status_t  status,
  output rne_pkg::cmd_t     cmd
);
  import rne_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd.load  = 1'b0;
    cmd.step  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_BUSY;
        end
      end
      ST_BUSY: begin
        // one character per cycle while the output register can take it
        cmd.step = !status.out_full || out_ready;
        if (cmd.step && status.step_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// File: rtl/roman_numeral_encoder_core.sv
// roman_numeral_encoder_core: top level, controller plus datapath
// first character: the input value is loaded into the remainder register, then a step registers it
// throughput: a numeral of n characters (1 to 15) is stepped out one character a cycle while
//   the output register can take it, by the single greedy symbol lookup
// the next item is taken while the final character still waits at the output
// reset: synchronous active-low rst_n clears the state machine and output valid
module roman_numeral_encoder_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rne_pkg::VALUE_W-1:0]  in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rne_pkg::CHAR_W-1:0]   out_char_code,
  output logic                         out_out_of_range,
  output logic                         out_last
);
  import rne_pkg::*;

  cmd_t    cmd;
  status_t status;

  rne_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rne_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_char_code    (out_char_code),
    .out_out_of_range (out_out_of_range),
    .out_last         (out_last)
  );

endmodule
